/* hdl/ceas_pkg.sv */
// ceas_pkg: shared types, register codes, reset values and the CORDIC arctangent table
// for the circle event angular score block. No dependencies.
package ceas_pkg;

  // Default sizing, handed to the top level as parameter defaults
  localparam int ANGLE_BUCKETS_DEF = 128;
  localparam int FRAC_BITS_DEF     = 4;
  localparam int CORDIC_STEPS_DEF  = 16;

  // CORDIC fixed sizing
  localparam int PRESCALE   = 16;
  localparam int ATAN_N     = 24;
  localparam int ATAN_IDX_W = 5;
  localparam int TURN_W     = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int CX_W       = 14;
  localparam int RAD_W      = 10;
  localparam int MRG_W      = 8;
  localparam int CNT_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INLIER_MARGIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_MARGIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SCORE      = 3'd5;

  localparam logic [RAD_W-1:0] RST_RADIUS         = 10'd160;
  localparam logic [MRG_W-1:0] RST_INLIER_MARGIN  = 8'd24;
  localparam logic [MRG_W-1:0] RST_OUTLIER_MARGIN = 8'd48;
  localparam logic [CNT_W-1:0] RST_MIN_SCORE      = 8'd20;

  // Opcodes and event classes
  localparam logic       OP_CLEAR      = 1'b0;
  localparam logic       OP_SCORE      = 1'b1;
  localparam logic [1:0] CLASS_NONE    = 2'd0;
  localparam logic [1:0] CLASS_INLIER  = 2'd1;
  localparam logic [1:0] CLASS_OUTLIER = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [8:0]  event_x;
    logic [8:0]  event_y;
    logic [31:0] event_dt;
  } ceas_in_t;

  typedef struct packed {
    logic [7:0]  best_score;
    logic [31:0] best_dt;
    logic [7:0]  inlier_count;
    logic [7:0]  outlier_count;
    logic [1:0]  event_class;
  } ceas_out_t;

  // atan(2^-i) in turns * 2^32
  function automatic logic [TURN_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic [TURN_W-1:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/ceas_ram.sv */
// ceas_ram: generic single-clock RAM, one write port and one registered read port.
// Depends on nothing.
module ceas_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/ceas_cordic.sv */
// ceas_cordic: iterative vectoring CORDIC that turns a center offset into an angle bucket.
// Depends on ceas_pkg (arctangent table, turn constants).
module ceas_cordic
  import ceas_pkg::*;
#(
  parameter int ANGLE_BUCKETS = ANGLE_BUCKETS_DEF,
  parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
  parameter int DX_W          = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [DX_W-1:0]           dx_i,
  input  logic signed [DX_W-1:0]           dy_i,
  output logic                             done_o,
  output logic [$clog2(ANGLE_BUCKETS)-1:0] bucket_o
);

  localparam int CW = DX_W + PRESCALE + 3;
  localparam int ZW = TURN_W + 2;
  localparam int UW = TURN_W + 1;
  localparam int AW = $clog2(ANGLE_BUCKETS);
  localparam int PW = UW + AW + 1;

  localparam logic signed [ZW-1:0] Z_QTR  = ZW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] Z_HALF = ZW'(64'sd2147483648);
  localparam logic [UW-1:0]        U_FULL = {1'b1, {TURN_W{1'b0}}};
  localparam logic [AW-1:0]        B_M1   = AW'(ANGLE_BUCKETS - 1);
  localparam logic [PW-1:0]        P_RND  = PW'(64'd2147483648);
  localparam logic [ATAN_IDX_W-1:0] IT_LAST = ATAN_IDX_W'(CORDIC_STEPS - 1);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_ITER = 2'd1;
  localparam logic [1:0] C_MUL  = 2'd2;
  localparam logic [1:0] C_RND  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [ATAN_IDX_W-1:0] it_q;
  logic signed [CW-1:0]  x_q, y_q;
  logic signed [ZW-1:0]  z_q;
  logic [PW-1:0]         prod_q;
  logic [AW-1:0]         bucket_q;
  logic                  done_q;

  logic signed [CW-1:0] dx_sc, dy_sc, x_sh, y_sh;
  logic signed [ZW-1:0] atan_z, u_s;
  logic [UW-1:0]        u_c;
  logic [PW-1:0]        rnd_sum;
  logic                 y_pos, zero_off;

  assign dx_sc    = CW'(dx_i) <<< PRESCALE;
  assign dy_sc    = CW'(dy_i) <<< PRESCALE;
  assign zero_off = (dx_i == '0) && (dy_i == '0);

  // Shared shift and add unit, one micro-rotation per cycle
  assign x_sh   = x_q >>> it_q;
  assign y_sh   = y_q >>> it_q;
  assign y_pos  = !y_q[CW-1] && (y_q != '0);
  assign atan_z = ZW'(atan_lut(it_q));

  // Angle to unsigned turns, clamped to a full turn
  always_comb begin
    u_s = z_q + Z_HALF;
    if (u_s[ZW-1]) begin
      u_c = '0;
    end else if (u_s[UW-1:0] > U_FULL) begin
      u_c = U_FULL;
    end else begin
      u_c = u_s[UW-1:0];
    end
  end

  assign rnd_sum = prod_q + P_RND;

  always_comb begin
    state_d = state_q;
    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          state_d = zero_off ? C_MUL : C_ITER;
        end
      end
      C_ITER: begin
        if (it_q == IT_LAST) begin
          state_d = C_MUL;
        end
      end
      C_MUL:   state_d = C_RND;
      C_RND:   state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == C_RND);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      C_IDLE: begin
        it_q <= '0;
        if (zero_off) begin
          z_q <= '0;
        end else if (!dx_i[DX_W-1]) begin
          x_q <= dx_sc;
          y_q <= dy_sc;
          z_q <= '0;
        end else if (!dy_i[DX_W-1]) begin
          x_q <= dy_sc;
          y_q <= -dx_sc;
          z_q <= Z_QTR;
        end else begin
          x_q <= -dy_sc;
          y_q <= dx_sc;
          z_q <= -Z_QTR;
        end
      end
      C_ITER: begin
        it_q <= it_q + 1'b1;
        if (y_pos) begin
          x_q <= x_q + y_sh;
          y_q <= y_q - x_sh;
          z_q <= z_q + atan_z;
        end else begin
          x_q <= x_q - y_sh;
          y_q <= y_q + x_sh;
          z_q <= z_q - atan_z;
        end
      end
      C_MUL: begin
        prod_q <= {{(PW-UW){1'b0}}, u_c} * {{(PW-AW){1'b0}}, B_M1};
      end
      C_RND: begin
        bucket_q <= rnd_sum[TURN_W +: AW];
      end
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign bucket_o = bucket_q;

endmodule

/* hdl/circle_event_angular_score.sv */
// circle_event_angular_score: top level, sequencer, squaring unit and score bookkeeping.
// Depends on ceas_pkg, ceas_cordic and ceas_ram.
//
// Usage
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one transaction per
//   command: opcode clear empties both bucket maps and the counts, or opcode score
//   classifies one event against the configured circle. Every command yields exactly
//   one result on the output channel (out_valid_o / out_stall_i / out_data_o) with the
//   best score, its event_dt, both counts and the event class. Configuration (cfg_we_i,
//   cfg_idx_i, cfg_wdata_i) must be written by the user only while idle; not enforced.
// Sequencing and rates
//   One command at a time; in_stall_o is high from acceptance until the result is
//   loaded into the output register, and the next command is taken in the cycle after.
//   An ignored event is paced by the shared squarer (six squares, one per cycle).
//   An inlier or inner outlier also runs the CORDIC loop, which performs one
//   micro-rotation per cycle.
//   Clear: one map row zeroed per cycle.
// Reset
//   Configuration and best score return to their reset values, then a clearing pass
//   zeroes every row of the map RAM; input stays stalled during it.
// Stalls
//   The result waits in the output register while out_stall_i is high; the next
//   command is still accepted and runs until its own result needs that register.
module circle_event_angular_score
  import ceas_pkg::*;
#(
  parameter int ANGLE_BUCKETS = ANGLE_BUCKETS_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ceas_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ceas_out_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int EX_W = 9 + FRAC_BITS;
  localparam int DX_W = ((EX_W > CX_W) ? EX_W : CX_W) + 2;
  localparam int SQ_W = 2 * DX_W;
  localparam int AW   = $clog2(ANGLE_BUCKETS);
  localparam int BW   = RAD_W + 2;

  localparam logic [AW-1:0]    SWEEP_LAST = AW'(ANGLE_BUCKETS - 1);
  localparam logic [CNT_W-1:0] CNT_SAT    = 8'd255;

  // Map row bits
  localparam int MAP_IN  = 0;
  localparam int MAP_OUT = 1;

  // Sequencer states
  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SQ    = 3'd2;
  localparam logic [2:0] S_CLASS = 3'd3;
  localparam logic [2:0] S_ANGLE = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_CLR   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // Squarer steps: which operand is squared in that cycle
  localparam logic [2:0] SQ_DX   = 3'd0;
  localparam logic [2:0] SQ_DY   = 3'd1;
  localparam logic [2:0] SQ_HI   = 3'd2;
  localparam logic [2:0] SQ_LO   = 3'd3;
  localparam logic [2:0] SQ_OLO  = 3'd4;
  localparam logic [2:0] SQ_R    = 3'd5;
  localparam logic [2:0] SQ_LAST = 3'd6;

  // Configuration registers
  logic signed [CX_W-1:0] cx_q, cy_q;
  logic [RAD_W-1:0]       radius_q;
  logic [MRG_W-1:0]       imargin_q, omargin_q;
  logic [CNT_W-1:0]       min_score_q;

  // Sequencer and datapath
  logic [2:0]             state_q, state_d;
  logic [2:0]             sq_step_q;
  logic [AW-1:0]          sweep_q, addr_q;
  logic signed [DX_W-1:0] dx_q, dy_q;
  logic [SQ_W-1:0]        sq_q, d2_q;
  logic                   lt_hi_q, gt_lo_q, gt_olo_q, lt_r_q;
  logic [31:0]            dt_q;
  logic [1:0]             cls_q;

  // Score state
  logic [CNT_W-1:0]       in_tot_q, out_tot_q, best_q;
  logic [31:0]            best_dt_q;

  // Output register
  logic                   out_valid_q;
  ceas_out_t              out_q;

  logic                   in_acc, out_load;
  logic signed [DX_W-1:0] ex_c, ey_c, sq_op;
  logic [SQ_W-1:0]        sq_c;
  logic signed [BW-1:0]   hi_c, lo_c, olo_c;
  logic                   inl_c, outl_c;
  logic                   cor_start, cor_done;
  logic [AW-1:0]          cor_bucket;
  logic                   map_we, map_re;
  logic [AW-1:0]          map_waddr;
  logic [1:0]             map_wdata, map_rdata;
  logic                   hit_new;
  logic [CNT_W-1:0]       in_tot_c, out_tot_c;
  logic signed [CNT_W:0]  score_c;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Event coordinates in fractional pixels
  assign ex_c = DX_W'(in_data_i.event_x) << FRAC_BITS;
  assign ey_c = DX_W'(in_data_i.event_y) << FRAC_BITS;

  // Band edges; a negative lower edge always passes
  assign hi_c  = BW'(radius_q) + BW'(imargin_q);
  assign lo_c  = BW'(radius_q) - BW'(imargin_q);
  assign olo_c = BW'(radius_q) - BW'(omargin_q);

  // Shared squarer, result registered before use
  always_comb begin
    case (sq_step_q)
      SQ_DX:   sq_op = dx_q;
      SQ_DY:   sq_op = dy_q;
      SQ_HI:   sq_op = DX_W'(hi_c);
      SQ_LO:   sq_op = DX_W'(lo_c);
      SQ_OLO:  sq_op = DX_W'(olo_c);
      SQ_R:    sq_op = DX_W'(BW'(radius_q));
      default: sq_op = '0;
    endcase
  end
  assign sq_c = SQ_W'(sq_op * sq_op);

  assign inl_c  = lt_hi_q && gt_lo_q;
  assign outl_c = !inl_c && lt_r_q && gt_olo_q;
  assign cor_start = (state_q == S_CLASS) && (inl_c || outl_c);

  // Map update: mark a bucket once, count it once, saturate the count
  always_comb begin
    hit_new   = 1'b0;
    in_tot_c  = in_tot_q;
    out_tot_c = out_tot_q;
    map_wdata = '0;
    if (cls_q == CLASS_INLIER) begin
      hit_new            = !map_rdata[MAP_IN];
      map_wdata          = map_rdata;
      map_wdata[MAP_IN]  = 1'b1;
      if (hit_new && in_tot_q < CNT_SAT) begin
        in_tot_c = in_tot_q + 1'b1;
      end
    end else if (cls_q == CLASS_OUTLIER) begin
      hit_new            = !map_rdata[MAP_OUT];
      map_wdata          = map_rdata;
      map_wdata[MAP_OUT] = 1'b1;
      if (hit_new && out_tot_q < CNT_SAT) begin
        out_tot_c = out_tot_q + 1'b1;
      end
    end
    score_c = $signed({1'b0, in_tot_c}) - $signed({1'b0, out_tot_c});
  end

  assign map_re    = cor_done;
  assign map_we    = (state_q == S_INIT) || (state_q == S_CLR) ||
                     ((state_q == S_UPD) && hit_new);
  assign map_waddr = (state_q == S_UPD) ? addr_q : sweep_q;

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (sweep_q == SWEEP_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = (in_data_i.opcode == OP_CLEAR) ? S_CLR : S_SQ;
        end
      end
      S_SQ: begin
        if (sq_step_q == SQ_LAST) begin
          state_d = S_CLASS;
        end
      end
      S_CLASS: state_d = cor_start ? S_ANGLE : S_DONE;
      S_ANGLE: begin
        if (cor_done) begin
          state_d = S_UPD;
        end
      end
      S_UPD: state_d = S_DONE;
      S_CLR: begin
        if (sweep_q == SWEEP_LAST) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state, configuration and score state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      sweep_q     <= '0;
      sq_step_q   <= '0;
      out_valid_q <= 1'b0;
      cx_q        <= '0;
      cy_q        <= '0;
      radius_q    <= RST_RADIUS;
      imargin_q   <= RST_INLIER_MARGIN;
      omargin_q   <= RST_OUTLIER_MARGIN;
      min_score_q <= RST_MIN_SCORE;
      in_tot_q    <= '0;
      out_tot_q   <= '0;
      best_q      <= RST_MIN_SCORE;
      best_dt_q   <= '0;
      cls_q       <= CLASS_NONE;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CENTER_X:       cx_q        <= cfg_wdata_i[CX_W-1:0];
          REG_CENTER_Y:       cy_q        <= cfg_wdata_i[CX_W-1:0];
          REG_RADIUS:         radius_q    <= cfg_wdata_i[RAD_W-1:0];
          REG_INLIER_MARGIN:  imargin_q   <= cfg_wdata_i[MRG_W-1:0];
          REG_OUTLIER_MARGIN: omargin_q   <= cfg_wdata_i[MRG_W-1:0];
          REG_MIN_SCORE:      min_score_q <= cfg_wdata_i[CNT_W-1:0];
          default: ;
        endcase
      end

      // Advance the clearing sweep, restart it on each clear command
      if (state_q == S_INIT || state_q == S_CLR) begin
        sweep_q <= sweep_q + 1'b1;
      end else begin
        sweep_q <= '0;
      end

      sq_step_q <= (state_q == S_SQ) ? sq_step_q + 1'b1 : '0;

      if (in_acc && in_data_i.opcode == OP_CLEAR) begin
        in_tot_q  <= '0;
        out_tot_q <= '0;
        best_q    <= min_score_q;
        best_dt_q <= '0;
        cls_q     <= CLASS_NONE;
      end

      if (state_q == S_CLASS) begin
        cls_q <= inl_c ? CLASS_INLIER : (outl_c ? CLASS_OUTLIER : CLASS_NONE);
      end

      if (state_q == S_UPD) begin
        in_tot_q  <= in_tot_c;
        out_tot_q <= out_tot_c;
        // Only an inlier can raise the best score
        if (cls_q == CLASS_INLIER && !score_c[CNT_W] && score_c[CNT_W-1:0] > best_q) begin
          best_q    <= score_c[CNT_W-1:0];
          best_dt_q <= dt_q;
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dx_q <= ex_c - DX_W'(cx_q);
      dy_q <= ey_c - DX_W'(cy_q);
      dt_q <= in_data_i.event_dt;
    end

    if (state_q == S_SQ) begin
      sq_q <= sq_c;
      // Consume the square produced in the previous cycle
      case (sq_step_q)
        SQ_DY:   d2_q     <= sq_q;
        SQ_HI:   d2_q     <= d2_q + sq_q;
        SQ_LO:   lt_hi_q  <= d2_q < sq_q;
        SQ_OLO:  gt_lo_q  <= lo_c[BW-1] || d2_q > sq_q;
        SQ_R:    gt_olo_q <= olo_c[BW-1] || d2_q > sq_q;
        SQ_LAST: lt_r_q   <= d2_q < sq_q;
        default: ;
      endcase
    end

    if (cor_done) begin
      addr_q <= cor_bucket;
    end

    if (out_load) begin
      out_q.best_score    <= best_q;
      out_q.best_dt       <= best_dt_q;
      out_q.inlier_count  <= in_tot_q;
      out_q.outlier_count <= out_tot_q;
      out_q.event_class   <= cls_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  ceas_cordic #(
    .ANGLE_BUCKETS (ANGLE_BUCKETS),
    .CORDIC_STEPS  (CORDIC_STEPS),
    .DX_W          (DX_W)
  ) u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cor_start),
    .dx_i     (dx_q),
    .dy_i     (dy_q),
    .done_o   (cor_done),
    .bucket_o (cor_bucket)
  );

  // One row per bucket: inlier mark and outlier mark
  ceas_ram #(
    .WIDTH (2),
    .DEPTH (ANGLE_BUCKETS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (cor_bucket),
    .rdata_o (map_rdata)
  );

  // The angle unit only reports while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> (state_q == S_ANGLE))
    else $error("angle unit finished outside the angle wait");

  // A map update only follows a classified event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (cls_q == CLASS_INLIER || cls_q == CLASS_OUTLIER))
    else $error("map update without an inlier or outlier class");

  // A clear command empties both counts in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.opcode == OP_CLEAR) |=> (in_tot_q == '0 && out_tot_q == '0))
    else $error("counts not emptied by clear");

  // Input stays stalled while a result is being formed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQ || state_q == S_ANGLE || state_q == S_UPD) |-> in_stall_o)
    else $error("input open while a command is in progress");

endmodule
